[rtl/fcrl_pkg.sv]
// Shared types, codes and default constants for the framed command/response link.
// No dependencies; fcrl_frame_tx, fcrl_exch_ctrl and the top level import this package.
package fcrl_pkg;

   // default build constants
   localparam int PAYLOAD_LEN_DEF    = 5;
   localparam int RESPONSE_LEN_DEF   = 8;
   localparam int TICKS_PER_UNIT_DEF = 120000;

   // fixed widths
   localparam int PAYLOAD_MAX = 5;
   localparam int TIME_W      = 25;
   localparam int TICKS_W     = 17;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   typedef logic [7:0] byte_type;

   // request kinds
   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // result kinds
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // exchange status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FRAME   = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // register indexes
   localparam logic REG_HEAD = 1'b0;
   localparam logic REG_TAIL = 1'b1;

   // one request as held in the input register
   typedef struct packed {
      logic [1:0] op;
      byte_type   cmd_byte;
      byte_type   param_one;
      byte_type   param_two;
      byte_type   param_three;
      byte_type   param_four;
      byte_type   wait_units;
      byte_type   rx_byte;
   } req_item_type;

   // status result offered by the exchange controller
   typedef struct packed {
      logic       emit;
      logic [1:0] status;
      byte_type   saved_two;
      byte_type   saved_three;
      byte_type   saved_four;
   } ctrl_result_type;

   // transmit byte offered by the frame sender
   typedef struct packed {
      byte_type tx_byte;
      logic     last;
   } tx_result_type;

endpackage

[rtl/fcrl_if.sv]
// Valid/ready channel interfaces for requests and results of the link.
// No dependencies.
interface fcrl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] cmd_byte;
   logic [7:0] param_one;
   logic [7:0] param_two;
   logic [7:0] param_three;
   logic [7:0] param_four;
   logic [7:0] wait_units;
   logic [7:0] rx_byte;

   modport source (output valid, op, cmd_byte, param_one, param_two, param_three,
                   param_four, wait_units, rx_byte, input ready);
   modport sink (input valid, op, cmd_byte, param_one, param_two, param_three,
                 param_four, wait_units, rx_byte, output ready);
endinterface

interface fcrl_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic       last;
   logic [1:0] status;
   logic [7:0] resp_byte_two;
   logic [7:0] resp_byte_three;
   logic [7:0] resp_byte_four;

   modport source (output valid, kind, tx_byte, last, status, resp_byte_two,
                   resp_byte_three, resp_byte_four, input ready);
   modport sink (input valid, kind, tx_byte, last, status, resp_byte_two,
                 resp_byte_three, resp_byte_four, output ready);
endinterface

[rtl/fcrl_frame_tx.sv]
// Frame sender: steps through header, payload, checksum and tail of a send request.
// Depends on fcrl_pkg.
module fcrl_frame_tx #(
   parameter int PAYLOAD_LEN = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fcrl_pkg::req_item_type item,
   input  fcrl_pkg::byte_type     head_byte,
   input  fcrl_pkg::byte_type     tail_byte,
   input  logic                   advance,
   output fcrl_pkg::tx_result_type tx
);
   import fcrl_pkg::*;

   localparam int FRAME_LEN = PAYLOAD_LEN + 3;
   localparam int IDX_W     = $clog2(FRAME_LEN);

   logic [IDX_W-1:0] idx_ff, idx_in;
   byte_type         payload [PAYLOAD_MAX];
   byte_type         sum;
   logic             at_last;

   // payload bytes in send order
   assign payload[0] = item.cmd_byte;
   assign payload[1] = item.param_one;
   assign payload[2] = item.param_two;
   assign payload[3] = item.param_three;
   assign payload[4] = item.param_four;

   // XOR checksum over the PAYLOAD_LEN payload bytes actually sent
   always_comb begin
      sum = '0;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         sum = sum ^ payload[i];
      end
   end

   assign at_last = (idx_ff == IDX_W'(FRAME_LEN - 1));

   // byte selection for the current position
   always_comb begin
      tx.last = at_last;
      if (idx_ff == '0) begin
         tx.tx_byte = head_byte;
      end else if (idx_ff == IDX_W'(PAYLOAD_LEN + 1)) begin
         tx.tx_byte = sum;
      end else if (at_last) begin
         tx.tx_byte = tail_byte;
      end else begin
         tx.tx_byte = '0;
         for (int i = 0; i < PAYLOAD_LEN; i++) begin
            if (idx_ff == IDX_W'(i + 1)) begin
               tx.tx_byte = payload[i];
            end
         end
      end
   end

   // position counter, wraps after the tail
   always_comb begin
      idx_in = idx_ff;
      if (advance) begin
         idx_in = at_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[rtl/fcrl_exch_ctrl.sv]
// Exchange controller: response checking, timeout countdown and status result.
// Depends on fcrl_pkg.
module fcrl_exch_ctrl #(
   parameter int RESPONSE_LEN   = 8,
   parameter int TICKS_PER_UNIT = 120000
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fcrl_pkg::req_item_type    item,
   input  fcrl_pkg::byte_type        head_byte,
   input  fcrl_pkg::byte_type        tail_byte,
   input  logic                      step,
   output fcrl_pkg::ctrl_result_type res
);
   import fcrl_pkg::*;

   localparam int CNT_W = $clog2(RESPONSE_LEN);
   localparam logic [TICKS_W-1:0] TICKS = TICKS_W'(TICKS_PER_UNIT);

   logic              waiting_ff, waiting_in;
   logic [CNT_W-1:0]  rx_count_ff, rx_count_in;
   byte_type          xor_acc_ff, xor_acc_in;
   logic [TIME_W-1:0] time_left_ff, time_left_in;
   byte_type          sent_ff, sent_in;
   logic              good_ff, good_in;
   byte_type          saved_ff [3];
   byte_type          saved_in [3];
   logic [TIME_W-1:0] time_load;
   byte_type          b;
   logic              final_pos;

   assign time_load = TIME_W'(item.wait_units) * TIME_W'(TICKS);
   assign b         = item.rx_byte;
   assign final_pos = (rx_count_ff == CNT_W'(RESPONSE_LEN - 1));

   // next exchange state and the status result for the held request
   always_comb begin
      waiting_in   = waiting_ff;
      rx_count_in  = rx_count_ff;
      xor_acc_in   = xor_acc_ff;
      time_left_in = time_left_ff;
      sent_in      = sent_ff;
      good_in      = good_ff;
      saved_in     = saved_ff;
      res          = '0;
      unique case (item.op)
         OP_SEND: begin
            waiting_in   = 1'b1;
            rx_count_in  = '0;
            xor_acc_in   = '0;
            good_in      = 1'b1;
            sent_in      = item.cmd_byte;
            saved_in     = '{default: '0};
            time_left_in = time_load;
         end
         OP_BYTE: begin
            if (waiting_ff) begin
               if (rx_count_ff == '0) begin
                  if (b != head_byte) good_in = 1'b0;
               end else if (final_pos) begin
                  if (b != tail_byte) good_in = 1'b0;
                  if (xor_acc_ff != '0) good_in = 1'b0;
               end else begin
                  if (rx_count_ff == CNT_W'(1) && b != sent_ff) good_in = 1'b0;
                  xor_acc_in = xor_acc_ff ^ b;
               end
               if (rx_count_ff == CNT_W'(2)) saved_in[0] = b;
               if (rx_count_ff == CNT_W'(3)) saved_in[1] = b;
               if (rx_count_ff == CNT_W'(4)) saved_in[2] = b;
               if (final_pos) begin
                  res.emit    = 1'b1;
                  res.status  = good_in ? ST_OK : ST_FRAME;
                  waiting_in  = 1'b0;
                  rx_count_in = '0;
               end else begin
                  rx_count_in = rx_count_ff + CNT_W'(1);
               end
            end
         end
         OP_TICK: begin
            if (waiting_ff) begin
               if (time_left_ff <= TIME_W'(1)) begin
                  time_left_in = '0;
                  res.emit     = 1'b1;
                  res.status   = ST_TIMEOUT;
                  waiting_in   = 1'b0;
                  rx_count_in  = '0;
               end else begin
                  time_left_in = time_left_ff - TIME_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
      res.saved_two   = saved_in[0];
      res.saved_three = saved_in[1];
      res.saved_four  = saved_in[2];
   end

   // state update when the held request is retired
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= 1'b0;
         rx_count_ff  <= '0;
         xor_acc_ff   <= '0;
         time_left_ff <= '0;
         sent_ff      <= '0;
         good_ff      <= 1'b1;
         saved_ff     <= '{default: '0};
      end else if (step) begin
         waiting_ff   <= waiting_in;
         rx_count_ff  <= rx_count_in;
         xor_acc_ff   <= xor_acc_in;
         time_left_ff <= time_left_in;
         sent_ff      <= sent_in;
         good_ff      <= good_in;
         saved_ff     <= saved_in;
      end
   end

endmodule

[rtl/framed_command_response_link.sv]
// Top level of the framed command/response link: request and result registers,
// register port. Depends on fcrl_pkg, fcrl_if, fcrl_frame_tx and fcrl_exch_ctrl.
//
//   channel   direction  handshake          carries
//   req_chan  in         valid/ready        send, received byte or tick
//   rsp_chan  out        valid/ready        transmit byte or exchange status
//   csr_*     in/out     psel/penable/pwrite head_byte (0x0), tail_byte (0x4)
//
// A send request holds the request register until the last of its PAYLOAD_LEN+3
// transmit bytes is loaded; other requests retire at once unless they emit a
// status into a full result register. Results pass from the request register into
// the result register, which is refilled in the cycle it is taken, so stalls on
// rsp_chan hold the request register and then req_chan. Reset is synchronous and
// clears control state and both registers to idle with no clearing pass.
module framed_command_response_link #(
   parameter int PAYLOAD_LEN    = fcrl_pkg::PAYLOAD_LEN_DEF,
   parameter int RESPONSE_LEN   = fcrl_pkg::RESPONSE_LEN_DEF,
   parameter int TICKS_PER_UNIT = fcrl_pkg::TICKS_PER_UNIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fcrl_req_if.sink    req_chan,
   fcrl_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fcrl_pkg::*;

   byte_type        head_ff, tail_ff;
   req_item_type    item_ff;
   logic            item_valid_ff, item_valid_in;
   logic            out_valid_ff, out_valid_in;
   logic            out_kind_ff, out_last_ff;
   byte_type        out_tx_ff, out_two_ff, out_three_ff, out_four_ff;
   logic [1:0]      out_status_ff;
   logic            out_space, is_send, step, out_load, take_req;
   ctrl_result_type ctrl_res;
   tx_result_type   tx_res;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DW'((csr_paddr[2] == REG_TAIL) ? tail_ff : head_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_HEAD: head_ff <= csr_pwdata[7:0];
            REG_TAIL: tail_ff <= csr_pwdata[7:0];
            default:  begin end
         endcase
      end
   end

   // retire control for the held request
   assign out_space = !out_valid_ff || rsp_chan.ready;
   assign is_send   = (item_ff.op == OP_SEND);
   assign out_load  = item_valid_ff && out_space && (is_send || ctrl_res.emit);
   assign step      = item_valid_ff &&
                      (is_send ? (out_space && tx_res.last) : (out_space || !ctrl_res.emit));
   assign take_req  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !item_valid_ff || step;

   // request register
   always_comb begin
      item_valid_in = item_valid_ff;
      if (take_req) begin
         item_valid_in = 1'b1;
      end else if (step) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         item_ff.op          <= req_chan.op;
         item_ff.cmd_byte    <= req_chan.cmd_byte;
         item_ff.param_one   <= req_chan.param_one;
         item_ff.param_two   <= req_chan.param_two;
         item_ff.param_three <= req_chan.param_three;
         item_ff.param_four  <= req_chan.param_four;
         item_ff.wait_units  <= req_chan.wait_units;
         item_ff.rx_byte     <= req_chan.rx_byte;
      end
   end

   // frame sender
   fcrl_frame_tx #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_frame_tx (
      .clock     (clock),
      .reset     (reset),
      .item      (item_ff),
      .head_byte (head_ff),
      .tail_byte (tail_ff),
      .advance   (item_valid_ff && is_send && out_space),
      .tx        (tx_res)
   );

   // exchange controller
   fcrl_exch_ctrl #(
      .RESPONSE_LEN   (RESPONSE_LEN),
      .TICKS_PER_UNIT (TICKS_PER_UNIT)
   ) u_exch_ctrl (
      .clock     (clock),
      .reset     (reset),
      .item      (item_ff),
      .head_byte (head_ff),
      .tail_byte (tail_ff),
      .step      (step),
      .res       (ctrl_res)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (is_send) begin
            out_kind_ff   <= KIND_TX;
            out_tx_ff     <= tx_res.tx_byte;
            out_last_ff   <= tx_res.last;
            out_status_ff <= ST_OK;
            out_two_ff    <= '0;
            out_three_ff  <= '0;
            out_four_ff   <= '0;
         end else begin
            out_kind_ff   <= KIND_STATUS;
            out_tx_ff     <= '0;
            out_last_ff   <= 1'b1;
            out_status_ff <= ctrl_res.status;
            out_two_ff    <= ctrl_res.saved_two;
            out_three_ff  <= ctrl_res.saved_three;
            out_four_ff   <= ctrl_res.saved_four;
         end
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.kind            = out_kind_ff;
   assign rsp_chan.tx_byte         = out_tx_ff;
   assign rsp_chan.last            = out_last_ff;
   assign rsp_chan.status          = out_status_ff;
   assign rsp_chan.resp_byte_two   = out_two_ff;
   assign rsp_chan.resp_byte_three = out_three_ff;
   assign rsp_chan.resp_byte_four  = out_four_ff;

endmodule
